FILE: design/ovl_pkg.sv
// Package: command codes, status codes and the result struct for the ordered value list.
`timescale 1ns / 1ps
package ovl_pkg;

  typedef enum logic [2:0] {
    FUNC_INSERT_AFTER = 3'd0,
    FUNC_DELETE_VALUE = 3'd1,
    FUNC_INSERT_FRONT = 3'd2,
    FUNC_INSERT_BACK  = 3'd3,
    FUNC_DELETE_FRONT = 3'd4,
    FUNC_DELETE_BACK  = 3'd5,
    FUNC_READ_ALL     = 3'd6,
    FUNC_NOP          = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic [31:0] read_value;
    status_e     status;
    logic        last;
    logic [4:0]  count;
  } result_t;

endpackage

FILE: design/ovl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module ovl_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/ordered_value_list.sv
// Top level of the ordered value list: linked node pool, walker and result register.
//
//   channel | direction | signals
//   --------+-----------+------------------------------------------------
//   in      | input     | in_valid_i, in_ready_o, func_i, key_i, value_i
//   out     | output    | out_valid_o, out_ready_i, read_value_o, status_o,
//           |           | last_o, count_o
//
// One command at a time. A command walks the list node by node through the
// node RAMs, whose read is registered: each node is read in S_RD and checked in
// S_CHK, and the walk waits in S_RD while a result is held. Inserts and deletes
// then write the links in S_LINK or S_UNLINK, and S_EMIT raises the result.
// The next item is taken only once that result has been taken.
// The walk through the link RAM sets how long a command takes.
// After reset a clearing pass chains the link RAM as the
// free list; no item is accepted during it.
// A stalled result holds its register; the walk halts until it is taken, and no
// new item is accepted while a result waits.
`timescale 1ns / 1ps
module ordered_value_list
  import ovl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] read_value_o,
  output logic [1:0]  status_o,
  output logic        last_o,
  output logic [4:0]  count_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = AW + 1;        // link width, holds null == CAPACITY
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD, S_CHK, S_LINK, S_UNLINK, S_ROUT, S_EMIT
  } state_e;

  state_e      state_q;
  logic [AW-1:0] init_q;
  func_e       func_q;
  logic [31:0] key_q, value_q;
  logic [LW-1:0] head_q, free_q, cur_q, prev_q, nxt_q, tgt_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] steps_q;
  logic        out_valid_q;
  logic        out_valid_d;
  result_t     res_q;

  // link RAM
  logic          lwe;
  logic [AW-1:0] lwaddr, lraddr;
  logic [LW-1:0] lwdata, lrdata;
  // value RAM
  logic          vwe;
  logic [AW-1:0] vwaddr;
  logic [31:0]   vwdata, vrdata;

  ovl_ram #(.Width(LW), .Depth(CAPACITY)) u_link_ram (
    .clk_i, .we_i(lwe), .waddr_i(lwaddr), .wdata_i(lwdata),
    .raddr_i(lraddr), .rdata_o(lrdata)
  );
  ovl_ram #(.Width(32), .Depth(CAPACITY)) u_value_ram (
    .clk_i, .we_i(vwe), .waddr_i(vwaddr), .wdata_i(vwdata),
    .raddr_i(lraddr), .rdata_o(vrdata)
  );

  // Take a new item only once the previous result has left the register.
  assign in_ready_o   = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o  = out_valid_q;
  assign read_value_o = res_q.read_value;
  assign status_o     = res_q.status;
  assign last_o       = res_q.last;
  assign count_o      = res_q.count;

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  logic is_search;
  assign is_search = (func_q == FUNC_INSERT_AFTER) || (func_q == FUNC_DELETE_VALUE);

  // Node under the walk is the last one: null link, or the walk bound reached.
  logic chk_end;
  assign chk_end = (lrdata == NIL) || (steps_q == CW'(CAPACITY - 1));

  // Read address: node under the walk, or the free head / insertion point.
  assign lraddr = (state_q == S_IDLE) ? free_q[AW-1:0] : cur_q[AW-1:0];

  // Raise valid on a read_all element or a single result, drop it on handshake.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if ((state_q == S_CHK) && (func_q == FUNC_READ_ALL)) out_valid_d = 1'b1;
    if ((state_q == S_EMIT) && out_free) out_valid_d = 1'b1;
  end

  // Write port driven in S_INIT, S_LINK and S_UNLINK (two writes split over
  // S_LINK / S_UNLINK phases, see below).
  logic          phase_q;
  always_comb begin
    lwe = 1'b0; lwaddr = '0; lwdata = '0;
    vwe = 1'b0; vwaddr = free_q[AW-1:0]; vwdata = value_q;
    case (state_q)
      S_INIT: begin
        lwe = 1'b1; lwaddr = init_q; lwdata = LW'(init_q) + LW'(1);
      end
      S_LINK: begin
        // phase 0: new node links to successor of target; phase 1: target to new
        if (!phase_q) begin
          lwe = 1'b1; lwaddr = free_q[AW-1:0]; lwdata = nxt_q;
          vwe = 1'b1;
        end else if (tgt_q != NIL) begin
          lwe = 1'b1; lwaddr = tgt_q[AW-1:0]; lwdata = free_q;
        end
      end
      S_UNLINK: begin
        // phase 0: predecessor skips target; phase 1: target joins free list
        if (!phase_q) begin
          lwe = (prev_q != NIL); lwaddr = prev_q[AW-1:0]; lwdata = nxt_q;
        end else begin
          lwe = 1'b1; lwaddr = tgt_q[AW-1:0]; lwdata = free_q;
        end
      end
      default: ;
    endcase
  end

  logic [LW-1:0] free_next_q; // link of the free head, captured at issue

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_q      <= '0;
      head_q      <= NIL;
      free_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
      func_q      <= FUNC_NOP;
      key_q       <= '0;
      value_q     <= '0;
      res_q       <= '0;
      cur_q       <= NIL;
      prev_q      <= NIL;
      nxt_q       <= NIL;
      tgt_q       <= NIL;
      steps_q     <= '0;
      free_next_q <= NIL;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_INIT: begin
          init_q <= init_q + AW'(1);
          if (init_q == AW'(CAPACITY - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            func_q  <= func_e'(func_i);
            key_q   <= key_i;
            value_q <= value_i;
            cur_q   <= head_q;
            prev_q  <= NIL;
            steps_q <= '0;
            phase_q <= 1'b0;
            state_q <= S_ROUT;
          end
        end
        S_ROUT: begin
          // link of free head is valid now (read issued in S_IDLE)
          free_next_q <= lrdata;
          case (func_q)
            FUNC_INSERT_AFTER, FUNC_INSERT_FRONT, FUNC_INSERT_BACK: begin
              if (free_q == NIL) begin
                res_q   <= '{32'd0, STATUS_FULL, 1'b1, 5'(cnt_q)};
                state_q <= S_EMIT;
              end else if (func_q == FUNC_INSERT_FRONT || head_q == NIL) begin
                tgt_q <= NIL; nxt_q <= head_q; state_q <= S_LINK;
              end else begin
                state_q <= S_RD;
              end
            end
            FUNC_DELETE_VALUE, FUNC_DELETE_FRONT, FUNC_DELETE_BACK: begin
              if (head_q == NIL) begin
                res_q   <= '{32'd0, STATUS_EMPTY, 1'b1, 5'(cnt_q)};
                state_q <= S_EMIT;
              end else begin
                state_q <= S_RD;
              end
            end
            FUNC_READ_ALL: begin
              if (head_q == NIL) begin
                res_q   <= '{32'd0, STATUS_EMPTY, 1'b1, 5'(cnt_q)};
                state_q <= S_EMIT;
              end else begin
                state_q <= S_RD;
              end
            end
            default: begin
              res_q   <= '{32'd0, STATUS_OK, 1'b1, 5'(cnt_q)};
              state_q <= S_EMIT;
            end
          endcase
        end
        S_RD: begin
          // cur_q presented to the RAMs this cycle
          if (out_free) state_q <= S_CHK;
        end
        S_CHK: begin
          // lrdata / vrdata hold the node at cur_q
          case (func_q)
            FUNC_READ_ALL: begin
              res_q   <= '{vrdata, STATUS_OK, chk_end, 5'(cnt_q)};
              cur_q   <= lrdata;
              steps_q <= steps_q + CW'(1);
              state_q <= chk_end ? S_IDLE : S_RD;
            end
            FUNC_DELETE_FRONT: begin
              tgt_q <= cur_q; nxt_q <= lrdata; prev_q <= NIL;
              state_q <= S_UNLINK;
            end
            default: begin
              if (is_search && vrdata == key_q) begin
                tgt_q <= cur_q; nxt_q <= lrdata;
                state_q <= (func_q == FUNC_INSERT_AFTER) ? S_LINK : S_UNLINK;
              end else if (chk_end) begin
                if (func_q == FUNC_DELETE_VALUE) begin
                  res_q <= '{32'd0, STATUS_NOT_FOUND, 1'b1, 5'(cnt_q)};
                  state_q <= S_EMIT;
                end else if (func_q == FUNC_DELETE_BACK) begin
                  tgt_q <= cur_q; nxt_q <= lrdata; state_q <= S_UNLINK;
                end else begin
                  // append at the tail
                  tgt_q <= cur_q; nxt_q <= lrdata; state_q <= S_LINK;
                end
              end else begin
                prev_q  <= cur_q;
                cur_q   <= lrdata;
                steps_q <= steps_q + CW'(1);
                state_q <= S_RD;
              end
            end
          endcase
        end
        S_LINK: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            if (tgt_q == NIL) head_q <= free_q;
            free_q  <= free_next_q;
            cnt_q   <= cnt_q + CW'(1);
            res_q   <= '{32'd0, STATUS_OK, 1'b1, 5'(cnt_q + CW'(1))};
            state_q <= S_EMIT;
          end
        end
        S_UNLINK: begin
          phase_q <= !phase_q;
          if (!phase_q) begin
            if (prev_q == NIL) head_q <= nxt_q;
          end else begin
            free_q  <= tgt_q;
            cnt_q   <= cnt_q - CW'(1);
            res_q   <= '{32'd0, STATUS_OK, 1'b1, 5'(cnt_q - CW'(1))};
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY)) else $error("element count above capacity");
  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((cnt_q == '0) == (head_q == NIL)))
    else $error("head and count disagree");
  a_full_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((cnt_q == CW'(CAPACITY)) == (free_q == NIL)))
    else $error("free list and count disagree");
  a_no_accept_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> !in_ready_o) else $error("item taken during clear");
`endif

endmodule

FILE: sim/tb_ordered_value_list.sv
// Testbench for the ordered value list: random and directed commands checked against a list model.
`timescale 1ns / 1ps
module tb_ordered_value_list;
  import ovl_pkg::*;

  localparam int CAP = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RUN_LIMIT = 500000;

  // Expected result of one output item.
  typedef struct {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic        last;
    logic [4:0]  count;
  } list_result_t;

  // Scoreboard: keep a plain array copy of the list and queue the results
  // each accepted command should produce.
  class list_scoreboard;
    logic [31:0] elems[$];
    list_result_t pending[$];
    int errors;
    int results_seen;
    int max_len;

    function void push_status(logic [1:0] st);
      list_result_t r;
      r.read_value = '0;
      r.status = st;
      r.last = 1'b1;
      r.count = 5'(elems.size());
      pending.push_back(r);
    endfunction

    // Apply one accepted command to the list copy and queue its results.
    function void note_command(logic [2:0] fn, logic [31:0] key, logic [31:0] val);
      int pos;
      list_result_t r;
      pos = -1;
      foreach (elems[i]) if (pos < 0 && elems[i] == key) pos = i;
      case (func_e'(fn))
        FUNC_INSERT_AFTER: begin
          if (elems.size() >= CAP) begin
            push_status(STATUS_FULL);
          end else begin
            if (pos < 0) elems.push_back(val);
            else elems.insert(pos + 1, val);
            push_status(STATUS_OK);
          end
        end
        FUNC_DELETE_VALUE: begin
          if (elems.size() == 0) push_status(STATUS_EMPTY);
          else if (pos < 0) push_status(STATUS_NOT_FOUND);
          else begin
            elems.delete(pos);
            push_status(STATUS_OK);
          end
        end
        FUNC_INSERT_FRONT, FUNC_INSERT_BACK: begin
          if (elems.size() >= CAP) push_status(STATUS_FULL);
          else begin
            if (func_e'(fn) == FUNC_INSERT_FRONT) elems.push_front(val);
            else elems.push_back(val);
            push_status(STATUS_OK);
          end
        end
        FUNC_DELETE_FRONT, FUNC_DELETE_BACK: begin
          if (elems.size() == 0) push_status(STATUS_EMPTY);
          else begin
            if (func_e'(fn) == FUNC_DELETE_FRONT) void'(elems.pop_front());
            else void'(elems.pop_back());
            push_status(STATUS_OK);
          end
        end
        FUNC_READ_ALL: begin
          if (elems.size() == 0) push_status(STATUS_EMPTY);
          else foreach (elems[i]) begin
            r.read_value = elems[i];
            r.status = STATUS_OK;
            r.last = (i == elems.size() - 1);
            r.count = 5'(elems.size());
            pending.push_back(r);
          end
        end
        default: push_status(STATUS_OK);
      endcase
      if (elems.size() > max_len) max_len = elems.size();
    endfunction

    function void check_result(logic [31:0] rv, logic [1:0] st, logic lst, logic [4:0] cnt);
      list_result_t e;
      results_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value=%h status=%0d last=%0d count=%0d",
                 $time, rv, st, lst, cnt);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (rv !== e.read_value) begin
        $display("%0t: read_value expected %h actual %h", $time, e.read_value, rv);
        errors++;
      end
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (lst !== e.last) begin
        $display("%0t: last expected %0d actual %0d", $time, e.last, lst);
        errors++;
      end
      if (cnt !== e.count) begin
        $display("%0t: count expected %0d actual %0d", $time, e.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  func_i = '0;
  logic signed [31:0] key_i = '0;
  logic signed [31:0] value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [31:0] read_value_o;
  logic [1:0]  status_o;
  logic        last_o;
  logic [4:0]  count_o;

  list_scoreboard sb = new();
  bit stim_done = 1'b0;
  bit hold_off_now = 1'b0;
  int commands_sent = 0;
  int idle_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  ordered_value_list #(.CAPACITY(CAP)) DUT (.*);

  // Mostly short gaps, now and then a long one, sometimes none.
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Offer one command; hold it until accepted, then note it.
  task automatic send_command(func_e fn, logic [31:0] key, logic [31:0] val);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= fn;
    key_i <= key;
    value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(fn, key, val);
    commands_sent++;
  endtask

  // Values close to what the list holds make key hits likely.
  function automatic logic [31:0] pick_value();
    int p;
    p = $urandom_range(9);
    if (p < 5) return $urandom_range(7);
    if (p < 7 && sb.elems.size() > 0) return sb.elems[$urandom_range(sb.elems.size() - 1)];
    if (p == 7) return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
    return $urandom;
  endfunction

  task automatic fill_and_drain();
    repeat (CAP + 1) send_command(FUNC_INSERT_BACK, '0, pick_value());
    send_command(FUNC_READ_ALL, '0, '0);
    repeat (CAP + 1) send_command(func_e'($urandom_range(1) ? FUNC_DELETE_FRONT
                                                            : FUNC_DELETE_BACK), '0, '0);
  endtask

  // Stimulus.
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: reads, deletes and insert_after on an empty list, then the boundary values.
    send_command(FUNC_READ_ALL, '0, '0);
    send_command(FUNC_DELETE_FRONT, '0, '0);
    send_command(FUNC_DELETE_BACK, '0, '0);
    send_command(FUNC_DELETE_VALUE, 32'h5, '0);
    send_command(FUNC_INSERT_AFTER, 32'h1, 32'h8000_0000);
    send_command(FUNC_DELETE_BACK, '0, '0);
    send_command(FUNC_INSERT_FRONT, '0, 32'h7fff_ffff);
    send_command(FUNC_INSERT_BACK, '0, 32'hffff_ffff);
    send_command(FUNC_INSERT_AFTER, 32'h7fff_ffff, 32'h0);
    send_command(FUNC_INSERT_AFTER, 32'h1234, 32'h5555_aaaa);
    send_command(FUNC_DELETE_VALUE, 32'h7fff_fffe, '0);
    send_command(FUNC_DELETE_VALUE, 32'h7fff_ffff, '0);
    send_command(FUNC_NOP, 32'hffff_ffff, 32'hffff_ffff);
    send_command(FUNC_READ_ALL, '0, '0);
    send_command(FUNC_DELETE_FRONT, '0, '0);
    // Fill past capacity with a long receiver hold-off, then drain to empty.
    hold_off_now = 1'b1;
    fill_and_drain();
    hold_off_now = 1'b0;
    // Random commands, biased toward inserts so the list grows.
    repeat (75) begin
      int p;
      p = $urandom_range(99);
      if (p < 45) send_command(func_e'($urandom_range(3) == 0 ? FUNC_INSERT_FRONT :
                                       $urandom_range(1) ? FUNC_INSERT_AFTER
                                                         : FUNC_INSERT_BACK),
                               pick_value(), pick_value());
      else if (p < 65) send_command(FUNC_DELETE_VALUE, pick_value(), $urandom);
      else if (p < 80) send_command(func_e'($urandom_range(5, 4)), $urandom, $urandom);
      else if (p < 97) send_command(FUNC_READ_ALL, $urandom, $urandom);
      else send_command(FUNC_NOP, $urandom, $urandom);
    end
    fill_and_drain();
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off during the fill phase.
  initial begin
    int g;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_now && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      g = gap_len();
      if (g > 0) begin
        out_ready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Check results and count stall cycles for the watchdog.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      sb.check_result(read_value_o, status_o, last_o, count_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // End of run.
  initial begin
    fork
      begin
        while (!(stim_done && sb.pending.size() == 0)) @(posedge clk_i);
        repeat (2 * CAP + 20) @(posedge clk_i);
      end
      begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending.size());
        sb.errors++;
      end
      begin
        repeat (RUN_LIMIT) @(posedge clk_i);
        $display("%0t: run limit reached, %0d results outstanding", $time, sb.pending.size());
        sb.errors++;
      end
    join_any
    $display("Ran %0d commands, %0d results checked, list reached %0d of %0d entries.",
             commands_sent, sb.results_seen, sb.max_len, CAP);
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
